@@ hdl/sensor_report_deframer_unit_macros.svh @@
// Assertion macros for the sensor report deframer RTL.
`ifndef SENSOR_REPORT_DEFRAMER_UNIT_MACROS_SVH
`define SENSOR_REPORT_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SRD_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/srd_pkg.sv @@
// Shared types and constants of the sensor report deframer.
`timescale 1ns / 1ps

package srd_pkg;

   localparam int MAX_OBS_DEF = 15;
   localparam int OBS_W       = 44;
   localparam int POS_W       = 7;
   localparam int RSP_DATA_W  = 72;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_CRC_BAD = 2'd1,
      STAT_SHORT   = 2'd2
   } report_status_type;

   // controller -> datapath
   typedef struct packed {
      logic              take;
      logic              ld_status;
      report_status_type st_code;
      logic              ld_obs;
      logic              emit_clr;
   } srd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_final;
      logic crc_match;
      logic emit_any;
      logic emit_last;
      logic out_free;
   } srd_stat_type;

endpackage

@@ hdl/srd_dpath.sv @@
// Datapath: header and observation registers, CRC, observation store, result register.
`timescale 1ns / 1ps

module srd_dpath #(
   parameter int MAX_OBS = srd_pkg::MAX_OBS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  srd_pkg::srd_cmd_type            cmd,
   output srd_pkg::srd_stat_type           stat,
   input  logic [7:0]                      req_byte,
   input  logic                            req_last,
   input  logic                            csr_valid,
   input  logic [3:0]                      csr_wdata,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [srd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int          AW         = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1;
   localparam logic [3:0]  VER_RESET  = 4'd1;
   localparam logic [7:0]  NIB_MASK   = 8'h0f;
   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [3:0]  OBS_LIMIT  = 4'(MAX_OBS);

   function automatic logic [31:0] crc_byte(input logic [31:0] crc_i, input logic [7:0] b);
      logic [31:0] c;
      c = crc_i ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   logic [3:0]                   ver_ff;
   logic [srd_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [srd_pkg::POS_W-1:0]    crc_end_ff, crc_end_in;
   logic [3:0]                   count_ff, count_in;
   logic                         vflag_ff, vflag_in;
   logic [15:0]                  ident_ff, ident_in;
   logic [31:0]                  crc_ff, crc_in;
   logic [31:0]                  rxcrc_ff, rxcrc_in;
   logic [srd_pkg::OBS_W-1:0]    asm_ff, asm_in;
   logic [2:0]                   off_ff, off_in;
   logic [3:0]                   idx_ff, idx_in;
   logic                         wr_en;
   logic [3:0]                   emit_idx_ff;
   logic [3:0]                   emit_n;
   logic [srd_pkg::OBS_W-1:0]    rd_data_ff;
   logic [srd_pkg::OBS_W-1:0]    store_mem [MAX_OBS];

   logic                         is_header;
   logic                         obs_region;
   logic [7:0]                   count_byte;

   // result register
   logic                         out_valid_ff;
   logic                         out_kind_ff;
   logic [15:0]                  out_ident_ff;
   logic [3:0]                   out_idx_ff;
   logic [srd_pkg::OBS_W-1:0]    out_rec_ff;
   srd_pkg::report_status_type   out_st_ff;
   logic                         out_vflag_ff;
   logic [3:0]                   out_count_ff;
   logic                         out_last_ff;

   assign is_header  = (pos_ff == '0);
   assign obs_region = !is_header && (pos_ff >= 7'd4) && (pos_ff < crc_end_ff);
   assign count_byte = req_byte & NIB_MASK;
   assign emit_n     = (count_ff < OBS_LIMIT) ? count_ff : OBS_LIMIT;

   assign stat.is_final  = !is_header && (pos_ff == crc_end_ff + 7'd3);
   assign stat.crc_match = (~crc_ff) == {rxcrc_ff[23:0], req_byte};
   assign stat.emit_any  = (emit_n != 4'd0);
   assign stat.emit_last = (emit_idx_ff == emit_n - 4'd1);
   assign stat.out_free  = !out_valid_ff || rsp_tready;

   always_comb begin
      pos_in     = pos_ff;
      crc_end_in = crc_end_ff;
      count_in   = count_ff;
      vflag_in   = vflag_ff;
      ident_in   = ident_ff;
      crc_in     = crc_ff;
      rxcrc_in   = rxcrc_ff;
      asm_in     = asm_ff;
      off_in     = off_ff;
      idx_in     = idx_ff;
      wr_en      = 1'b0;
      if (cmd.take) begin
         if (is_header) begin
            vflag_in   = (req_byte[7:4] != ver_ff);
            count_in   = count_byte[3:0];
            crc_end_in = {1'b0, count_byte[3:0], 2'b00} + {2'b00, count_byte[3:0], 1'b0}
                         + 7'd4;
            ident_in   = '0;
            rxcrc_in   = '0;
            asm_in     = '0;
            off_in     = '0;
            idx_in     = '0;
            crc_in     = crc_byte('1, req_byte);
         end else if (pos_ff < crc_end_ff) begin
            crc_in = crc_byte(crc_ff, req_byte);
            if (pos_ff == 7'd2 || pos_ff == 7'd3) begin
               ident_in = {ident_ff[7:0], req_byte};
            end
         end else begin
            rxcrc_in = {rxcrc_ff[23:0], req_byte};
         end
         if (obs_region) begin
            case (off_ff)
               3'd0:    asm_in = {req_byte, 36'd0};
               3'd1:    asm_in = asm_ff | {8'd0, req_byte[7:4], 32'd0};
               3'd2:    asm_in = asm_ff | (srd_pkg::OBS_W'(req_byte) << 24);
               3'd3:    asm_in = asm_ff | (srd_pkg::OBS_W'(req_byte) << 16);
               3'd4:    asm_in = asm_ff | (srd_pkg::OBS_W'(req_byte) << 8);
               default: asm_in = asm_ff | srd_pkg::OBS_W'(req_byte);
            endcase
            if (off_ff == 3'd5) begin
               off_in = '0;
               idx_in = idx_ff + 4'd1;
               wr_en  = (idx_ff < OBS_LIMIT);
            end else begin
               off_in = off_ff + 3'd1;
            end
         end
         pos_in = (stat.is_final || req_last) ? '0 : pos_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ver_ff <= VER_RESET;
         pos_ff <= '0;
      end else begin
         if (csr_valid) begin
            ver_ff <= csr_wdata;
         end
         pos_ff <= pos_in;
      end
      crc_end_ff <= crc_end_in;
      count_ff   <= count_in;
      vflag_ff   <= vflag_in;
      ident_ff   <= ident_in;
      crc_ff     <= crc_in;
      rxcrc_ff   <= rxcrc_in;
      asm_ff     <= asm_in;
      off_ff     <= off_in;
      idx_ff     <= idx_in;
   end

   // observation store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[idx_ff[AW-1:0]] <= asm_in;
      end
      rd_data_ff <= store_mem[emit_idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_clr) begin
         emit_idx_ff <= '0;
      end else if (cmd.ld_obs) begin
         emit_idx_ff <= emit_idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.ld_status || cmd.ld_obs) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.ld_status) begin
         out_kind_ff  <= 1'b1;
         out_ident_ff <= ident_in;
         out_idx_ff   <= '0;
         out_rec_ff   <= '0;
         out_st_ff    <= cmd.st_code;
         out_vflag_ff <= vflag_in;
         out_count_ff <= count_in;
         out_last_ff  <= 1'b1;
      end else if (cmd.ld_obs) begin
         out_kind_ff  <= 1'b0;
         out_ident_ff <= ident_ff;
         out_idx_ff   <= emit_idx_ff;
         out_rec_ff   <= rd_data_ff;
         out_st_ff    <= srd_pkg::STAT_OK;
         out_vflag_ff <= vflag_ff;
         out_count_ff <= count_ff;
         out_last_ff  <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_count_ff, out_vflag_ff, out_st_ff, out_rec_ff[31:0],
                        out_rec_ff[35:32], out_rec_ff[43:36], out_idx_ff, out_ident_ff};

endmodule

@@ hdl/srd_ctrl.sv @@
// Controller: sequences byte intake, report emission and skipping of trailing bytes.
`timescale 1ns / 1ps

module srd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tlast,
   output logic                   req_tready,
   input  srd_pkg::srd_stat_type  stat,
   output srd_pkg::srd_cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_RUN,
      S_SKIP,
      S_READ,
      S_LOAD,
      S_STATUS
   } state_type;

   state_type state_ff, state_in;
   logic      skip_ff, skip_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      skip_in    = skip_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_RUN: begin
            // a word may produce a status item, so intake waits on a free result register
            req_tready = stat.out_free;
            if (req_tvalid && stat.out_free) begin
               cmd.take = 1'b1;
               if (stat.is_final) begin
                  skip_in = !req_tlast;
                  if (stat.crc_match && stat.emit_any) begin
                     cmd.emit_clr = 1'b1;
                     state_in     = S_READ;
                  end else begin
                     cmd.ld_status = 1'b1;
                     cmd.st_code   = stat.crc_match ? srd_pkg::STAT_OK : srd_pkg::STAT_CRC_BAD;
                     state_in      = req_tlast ? S_RUN : S_SKIP;
                  end
               end else if (req_tlast) begin
                  cmd.ld_status = 1'b1;
                  cmd.st_code   = srd_pkg::STAT_SHORT;
               end
            end
         end
         S_SKIP: begin
            req_tready = 1'b1;
            if (req_tvalid && req_tlast) begin
               state_in = S_RUN;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (stat.out_free) begin
               cmd.ld_obs = 1'b1;
               state_in   = stat.emit_last ? S_STATUS : S_READ;
            end
         end
         S_STATUS: begin
            if (stat.out_free) begin
               cmd.ld_status = 1'b1;
               cmd.st_code   = srd_pkg::STAT_OK;
               state_in      = skip_ff ? S_SKIP : S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
         skip_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

@@ hdl/sensor_report_deframer_unit.sv @@
// Top level of the sensor report deframer: controller, datapath and port mapping.
`timescale 1ns / 1ps

// Decodes a framed sensor report one byte per word: header (version, count n),
// padding, 16-bit sensor id, n six-byte observations and a trailing CRC-32 over
// all earlier bytes; the message is 8+6n bytes. Bytes are taken at one per cycle
// while the message is parsed, but every byte waits while a result word sits
// untaken in the result register. After the last CRC byte a good report with
// n above zero is sent as its observations (each through a read state and a load
// state, since the observation store read is registered; n capped at MAX_OBS), then
// an ok status word; input is held off until that status word has been loaded.
// A CRC failure, a good report with no observations or a buffer that ends early
// yields a single status word, loaded as the last byte is taken. Bytes after a complete
// message are dropped up to the end-of-buffer mark. The version field is only
// flagged against the csr register (reset value 1). No clearing pass after reset.
`include "sensor_report_deframer_unit_macros.svh"

module sensor_report_deframer_unit #(
   parameter int MAX_OBS = srd_pkg::MAX_OBS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // [7:0] data_byte
   input  logic [7:0]                      req_tdata,
   input  logic                            req_tlast,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] sensor_ident, [19:16] obs_index, [27:20] phenomenon_code,
   // [31:28] value_kind, [63:32] value_bits, [65:64] report_status,
   // [66] version_mismatch, [70:67] obs_count, [71] zero
   output logic [srd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] item_kind
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [3:0]                      csr_wdata
);

   srd_pkg::srd_cmd_type  cmd;
   srd_pkg::srd_stat_type stat;

   assign csr_ready = 1'b1;

   srd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   srd_dpath #(
      .MAX_OBS (MAX_OBS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_byte   (req_tdata),
      .req_last   (req_tlast),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `SRD_ASSERT_IMPLIES(a_no_overwrite, cmd.ld_status || cmd.ld_obs, !rsp_tvalid || rsp_tready, "result word overwritten before it was taken")
   `SRD_ASSERT_NEXT(a_load_shows, cmd.ld_status || cmd.ld_obs, rsp_tvalid, "loaded result word not presented")
   `SRD_ASSERT_IMPLIES(a_last_is_status, rsp_tvalid, rsp_tlast == rsp_tuser, "end of report does not coincide with the status word")
   `SRD_ASSERT_IMPLIES(a_index_in_range, rsp_tvalid && !rsp_tuser, rsp_tdata[19:16] < rsp_tdata[70:67], "observation index beyond announced count")

endmodule
